// ----- rtl/cca_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cca_pkg
// Shared types and constants of the cave cellular automaton step block:
// field widths, operation codes, register indexes and the command word
// that the controller hands to the datapath.
// ----------------------------------------------------------------------------
package cca_pkg;

    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 64;

    localparam int OP_W        = 2;
    localparam int COORD_W     = 6;
    localparam int CFG_W       = 7;
    localparam int LIMIT_W     = 4;
    localparam int COUNT_W     = 4;
    localparam int CFG_INDEX_W = 2;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_GEN   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLUMNS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BIRTH_LIMIT  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEATH_LIMIT  = 2'd3;

    localparam logic [CFG_W-1:0]   RST_GRID_COLUMNS = 7'd64;
    localparam logic [CFG_W-1:0]   RST_GRID_ROWS    = 7'd64;
    localparam logic [LIMIT_W-1:0] RST_BIRTH_LIMIT  = 4'd4;
    localparam logic [LIMIT_W-1:0] RST_DEATH_LIMIT  = 4'd3;

    typedef logic [1:0] wr_mode_t;

    localparam wr_mode_t WM_CLEAR = 2'd0;
    localparam wr_mode_t WM_CELL  = 2'd1;
    localparam wr_mode_t WM_GEN   = 2'd2;

    typedef struct packed {
        logic     load;
        logic     rd_en;
        logic     shift;
        logic     wr_en;
        wr_mode_t wr_mode;
        logic     top_out;
        logic     bot_out;
        logic     resp;
        logic     resp_done;
        logic     resp_read;
    } dp_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/cca_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cca_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module cca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/cca_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cca_ctrl
// Controller of the cave automaton: clearing pass after reset, cell write
// (read-modify-write), cell read (three-row window) and the generation
// sweep, one row per cycle.
// ----------------------------------------------------------------------------
module cca_ctrl
    import cca_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int AW       = $clog2(MAX_ROWS),
    parameter int CNT_W    = $clog2(MAX_ROWS + 2)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [OP_W-1:0]    operation,
    input  wire logic [COORD_W-1:0] column,
    input  wire logic [COORD_W-1:0] row,
    input  wire logic [CFG_W-1:0]   eff_cols,
    input  wire logic [CNT_W-1:0]   eff_rows,
    output logic                    busy,
    output dp_cmd_t                 cmd,
    output logic      [AW-1:0]      rd_addr,
    output logic      [AW-1:0]      wr_addr
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WR_RD = 3'd2;
    localparam logic [2:0] S_WR_WR = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_GEN   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [AW-1:0]    row_reg, row_next;
    logic             top_reg, top_next;
    logic             bot_reg, bot_next;
    logic             in_grid;

    assign in_grid = (column < eff_cols) && (row < eff_rows);
    assign busy    = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        top_reg <= top_next;
        bot_reg <= bot_next;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        row_next   = row_reg;
        top_next   = top_reg;
        bot_next   = bot_reg;
        cmd        = '0;
        rd_addr    = row_reg;
        wr_addr    = row_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_mode = WM_CLEAR;
                wr_addr     = AW'(step_reg);
                if (step_reg == CNT_W'(MAX_ROWS - 1))
                begin
                    state_next = S_IDLE;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + CNT_W'(1);
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load  = 1'b1;
                    row_next  = AW'(row);
                    top_next  = (row == '0);
                    bot_next  = ((CFG_W'(row) + CFG_W'(1)) >= eff_rows);
                    step_next = '0;
                    case (operation)
                        OP_WRITE:
                        begin
                            if (in_grid)
                            begin
                                state_next = S_WR_RD;
                            end
                            else
                            begin
                                cmd.resp      = 1'b1;
                                cmd.resp_done = 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if (in_grid)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                cmd.resp      = 1'b1;
                                cmd.resp_done = 1'b1;
                            end
                        end
                        OP_GEN:
                        begin
                            if (eff_rows != '0)
                            begin
                                state_next = S_GEN;
                            end
                            else
                            begin
                                cmd.resp      = 1'b1;
                                cmd.resp_done = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd.resp = 1'b1;
                        end
                    endcase
                end
            end
            S_WR_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_WR_WR;
            end
            S_WR_WR:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_mode   = WM_CELL;
                cmd.resp      = 1'b1;
                cmd.resp_done = 1'b1;
                state_next    = S_IDLE;
            end
            S_READ:
            begin
                step_next = step_reg + CNT_W'(1);
                if (step_reg == CNT_W'(0))
                begin
                    cmd.rd_en = !top_reg;
                    rd_addr   = row_reg - AW'(1);
                end
                else if (step_reg == CNT_W'(1))
                begin
                    cmd.rd_en = 1'b1;
                    cmd.shift = 1'b1;
                end
                else if (step_reg == CNT_W'(2))
                begin
                    cmd.rd_en = !bot_reg;
                    cmd.shift = 1'b1;
                    rd_addr   = row_reg + AW'(1);
                end
                else
                begin
                    cmd.top_out   = top_reg;
                    cmd.bot_out   = bot_reg;
                    cmd.resp      = 1'b1;
                    cmd.resp_done = 1'b1;
                    cmd.resp_read = 1'b1;
                    state_next    = S_IDLE;
                    step_next     = '0;
                end
            end
            S_GEN:
            begin
                cmd.rd_en = (step_reg < eff_rows);
                rd_addr   = AW'(step_reg);
                cmd.shift = (step_reg != '0);
                wr_addr   = AW'(step_reg - CNT_W'(2));
                step_next = step_reg + CNT_W'(1);
                if (step_reg >= CNT_W'(2))
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_mode = WM_GEN;
                    cmd.top_out = (step_reg == CNT_W'(2));
                    cmd.bot_out = (step_reg == (eff_rows + CNT_W'(1)));
                end
                if (step_reg == (eff_rows + CNT_W'(1)))
                begin
                    cmd.resp      = 1'b1;
                    cmd.resp_done = 1'b1;
                    state_next    = S_IDLE;
                    step_next     = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                step_next  = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/cca_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cca_datapath
// Grid memory, three-row window, neighbour counters for every column of a
// row, next-row rule and the registered result word.
// ----------------------------------------------------------------------------
module cca_datapath
    import cca_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int AW          = $clog2(MAX_ROWS),
    parameter int CW          = $clog2(MAX_COLUMNS)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_cmd_t            cmd,
    input  wire logic [AW-1:0]      rd_addr,
    input  wire logic [AW-1:0]      wr_addr,
    input  wire logic [COORD_W-1:0] column,
    input  wire logic               cell_value,
    input  wire logic [CFG_W-1:0]   eff_cols,
    input  wire logic [LIMIT_W-1:0] birth_limit,
    input  wire logic [LIMIT_W-1:0] death_limit,
    output logic                    strobe,
    output logic                    cell_alive,
    output logic      [COUNT_W-1:0] neighbour_count,
    output logic                    done_res
);

    logic [MAX_COLUMNS-1:0] rd_data;
    logic [MAX_COLUMNS-1:0] wr_data;
    logic [MAX_COLUMNS-1:0] old_row_above_reg;
    logic [MAX_COLUMNS-1:0] old_row_current_reg;
    logic [MAX_COLUMNS-1:0] colmask;
    logic [MAX_COLUMNS-1:0] next_row;
    logic [MAX_COLUMNS-1:0] cell_row;
    logic [MAX_COLUMNS+1:0] up_ext;
    logic [MAX_COLUMNS+1:0] mid_ext;
    logic [MAX_COLUMNS+1:0] dn_ext;
    logic [COUNT_W-1:0]     count [MAX_COLUMNS];
    logic [CW-1:0]          col_reg;
    logic                   value_reg;
    logic                   strobe_reg;
    logic                   cell_alive_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic                   done_res_reg;

    cca_ram #(
        .WIDTH (MAX_COLUMNS),
        .DEPTH (MAX_ROWS),
        .AW    (AW)
    ) u_grid (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            col_reg   <= CW'(column);
            value_reg <= cell_value;
        end
        if (cmd.shift)
        begin
            old_row_above_reg   <= old_row_current_reg;
            old_row_current_reg <= rd_data;
        end
    end

    // cells outside the grid count as alive
    always_comb
    begin
        for (int c = 0; c < MAX_COLUMNS; c++)
        begin
            colmask[c] = (c < int'(eff_cols));
        end
        up_ext  = cmd.top_out ? '1 : {1'b1, old_row_above_reg | ~colmask, 1'b1};
        mid_ext = {1'b1, old_row_current_reg | ~colmask, 1'b1};
        dn_ext  = cmd.bot_out ? '1 : {1'b1, rd_data | ~colmask, 1'b1};
    end

    always_comb
    begin
        for (int c = 0; c < MAX_COLUMNS; c++)
        begin
            count[c] = COUNT_W'(up_ext[c]) + COUNT_W'(up_ext[c+1]) + COUNT_W'(up_ext[c+2])
                     + COUNT_W'(mid_ext[c]) + COUNT_W'(mid_ext[c+2])
                     + COUNT_W'(dn_ext[c]) + COUNT_W'(dn_ext[c+1]) + COUNT_W'(dn_ext[c+2]);
            if (!colmask[c])
            begin
                next_row[c] = old_row_current_reg[c];
            end
            else if (old_row_current_reg[c])
            begin
                next_row[c] = !(count[c] < death_limit);
            end
            else
            begin
                next_row[c] = (count[c] > birth_limit);
            end
            cell_row[c] = (c == int'(col_reg)) ? value_reg : rd_data[c];
        end
    end

    always_comb
    begin
        case (cmd.wr_mode)
            WM_CELL: wr_data = cell_row;
            WM_GEN:  wr_data = next_row;
            default: wr_data = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.resp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resp)
        begin
            done_res_reg <= cmd.resp_done;
            if (cmd.resp_read)
            begin
                cell_alive_reg <= old_row_current_reg[col_reg];
                count_reg      <= count[col_reg];
            end
            else
            begin
                cell_alive_reg <= 1'b0;
                count_reg      <= '0;
            end
        end
    end

    assign strobe          = strobe_reg;
    assign cell_alive      = cell_alive_reg;
    assign neighbour_count = count_reg;
    assign done_res        = done_res_reg;

endmodule
`default_nettype wire

// ----- rtl/cave_cellular_automaton_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cave_cellular_automaton_step
// Cave-generation cellular automaton on a grid of one-bit cells with
// Moore-neighbour counting; cells outside the grid count as alive.
//
// Usage:
//   a word is taken when start is high and busy is low; operation selects
//   cell write, cell read or one generation over the grid
//   each word gives exactly one result, shown for one cycle with strobe high;
//   the receiver cannot hold it off and busy is already low in that cycle
//   generation: one row per cycle through the single read and single write
//   port of the grid memory
//   a write or read outside the grid, an empty generation and an unknown
//   operation are answered straight from idle, without a memory access
//   configuration writes go through cfg_valid / cfg_ready (always ready)
//   and belong to idle periods only, kept so by the user, not the block
//   after reset the grid memory is swept to zero, one row a cycle, over all
//   MAX_ROWS rows; busy stays high until that clearing pass is over
// ----------------------------------------------------------------------------
module cave_cellular_automaton_step
    import cca_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [OP_W-1:0]        operation,
    input  wire logic [COORD_W-1:0]     column,
    input  wire logic [COORD_W-1:0]     row,
    input  wire logic                   cell_value,
    output logic                        strobe,
    output logic                        cell_alive,
    output logic      [COUNT_W-1:0]     neighbour_count,
    output logic                        done_res,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    localparam int AW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int CNT_W = $clog2(MAX_ROWS + 2);

    logic [CFG_W-1:0]   grid_columns_reg;
    logic [CFG_W-1:0]   grid_rows_reg;
    logic [LIMIT_W-1:0] birth_limit_reg;
    logic [LIMIT_W-1:0] death_limit_reg;
    logic [CFG_W-1:0]   eff_cols;
    logic [CNT_W-1:0]   eff_rows;
    dp_cmd_t            cmd;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_columns_reg <= RST_GRID_COLUMNS;
            grid_rows_reg    <= RST_GRID_ROWS;
            birth_limit_reg  <= RST_BIRTH_LIMIT;
            death_limit_reg  <= RST_DEATH_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GRID_COLUMNS: grid_columns_reg <= cfg_data;
                REG_GRID_ROWS:    grid_rows_reg    <= cfg_data;
                REG_BIRTH_LIMIT:  birth_limit_reg  <= cfg_data[LIMIT_W-1:0];
                REG_DEATH_LIMIT:  death_limit_reg  <= cfg_data[LIMIT_W-1:0];
                default:          grid_columns_reg <= grid_columns_reg;
            endcase
        end
    end

    // oversized grid saturates to the built size
    assign eff_cols = (int'(grid_columns_reg) > MAX_COLUMNS) ? CFG_W'(MAX_COLUMNS)
                                                              : grid_columns_reg;
    assign eff_rows = (int'(grid_rows_reg) > MAX_ROWS) ? CNT_W'(MAX_ROWS)
                                                        : CNT_W'(grid_rows_reg);

    cca_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .AW       (AW),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .column    (column),
        .row       (row),
        .eff_cols  (eff_cols),
        .eff_rows  (eff_rows),
        .busy      (busy),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr)
    );

    cca_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .AW          (AW),
        .CW          (CW)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .rd_addr         (rd_addr),
        .wr_addr         (wr_addr),
        .column          (column),
        .cell_value      (cell_value),
        .eff_cols        (eff_cols),
        .birth_limit     (birth_limit_reg),
        .death_limit     (death_limit_reg),
        .strobe          (strobe),
        .cell_alive      (cell_alive),
        .neighbour_count (neighbour_count),
        .done_res        (done_res)
    );

endmodule
`default_nettype wire
